[src/htenc_pkg.sv]
// shared types, codes and helper functions for the html text encoder
// no dependencies; imported by every module of the block
package htenc_pkg;

    // byte codes used by the classifier and the expander
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_HSH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam logic [7:0] WRAP_RESET = 8'd70;

    // front state codes
    localparam logic [1:0] PH_TEXT    = 2'd0;
    localparam logic [1:0] PH_HELD    = 2'd1;
    localparam logic [1:0] PH_HELD_WS = 2'd2;
    localparam logic [1:0] PH_SWALLOW = 2'd3;

    // prefix kinds
    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_BR   = 2'd1;
    localparam logic [1:0] PFX_PARA = 2'd2;

    // body kinds
    localparam logic [2:0] BODY_NONE = 3'd0;
    localparam logic [2:0] BODY_AMP  = 3'd1;
    localparam logic [2:0] BODY_LT   = 3'd2;
    localparam logic [2:0] BODY_GT   = 3'd3;
    localparam logic [2:0] BODY_NL   = 3'd4;
    localparam logic [2:0] BODY_LIT  = 3'd5;
    localparam logic [2:0] BODY_REF  = 3'd6;

    // fixed string selectors
    localparam logic [2:0] STR_BR   = 3'd0;
    localparam logic [2:0] STR_PARA = 3'd1;
    localparam logic [2:0] STR_AMP  = 3'd2;
    localparam logic [2:0] STR_LT   = 3'd3;
    localparam logic [2:0] STR_GT   = 3'd4;

    // command queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // one classified item: optional line-break prefix plus one body token
    typedef struct packed {
        logic [1:0] prefix;
        logic [2:0] body;
        logic [7:0] chr;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // column add with saturation at 255
    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [2:0] k);
        logic [8:0] s;
        s = {1'b0, a} + {6'd0, k};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    // binary to three bcd digits, shift-and-add-3
    function automatic logic [11:0] to_bcd(input logic [7:0] v);
        logic [19:0] sh;
        sh = {12'd0, v};
        for (int i = 0; i < 8; i++)
        begin
            if (sh[11:8] > 4'd4)
                sh[11:8] = sh[11:8] + 4'd3;
            if (sh[15:12] > 4'd4)
                sh[15:12] = sh[15:12] + 4'd3;
            if (sh[19:16] > 4'd4)
                sh[19:16] = sh[19:16] + 4'd3;
            sh = sh << 1;
        end
        return sh[19:8];
    endfunction

    // bytes of the fixed strings
    function automatic logic [7:0] str_byte(input logic [2:0] sel, input logic [2:0] idx);
        logic [7:0] b;
        b = CH_SP;
        case (sel)
            STR_BR:
            begin
                case (idx)
                    3'd0: b = CH_LT;
                    3'd1: b = 8'h62;
                    3'd2: b = 8'h72;
                    3'd3: b = CH_GT;
                    default: b = CH_LF;
                endcase
            end
            STR_PARA:
            begin
                case (idx)
                    3'd0: b = CH_LF;
                    3'd1: b = CH_LT;
                    3'd2: b = 8'h70;
                    3'd3: b = CH_GT;
                    default: b = CH_LF;
                endcase
            end
            STR_AMP:
            begin
                case (idx)
                    3'd0: b = CH_AMP;
                    3'd1: b = 8'h61;
                    3'd2: b = 8'h6D;
                    3'd3: b = 8'h70;
                    default: b = CH_SEMI;
                endcase
            end
            STR_LT:
            begin
                case (idx)
                    3'd0: b = CH_AMP;
                    3'd1: b = 8'h6C;
                    3'd2: b = 8'h74;
                    default: b = CH_SEMI;
                endcase
            end
            default:
            begin
                case (idx)
                    3'd0: b = CH_AMP;
                    3'd1: b = 8'h67;
                    3'd2: b = 8'h74;
                    default: b = CH_SEMI;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

[src/htenc_front.sv]
// front end: takes input bytes, tracks newline and column state, classifies
// each byte into a command for the queue; depends on htenc_pkg
module htenc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // in_byte
    input  logic                s_tlast,   // in_last
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data,  // wrap_column
    input  htenc_pkg::q_stat_t  q_stat,
    output logic                push,
    output htenc_pkg::cmd_t     push_cmd
);
    import htenc_pkg::*;

    logic [7:0] wrap_reg;
    logic [1:0] phase_reg, phase_next;
    logic       para_reg, para_next;
    logic [7:0] col_reg, col_next;
    logic       accept;
    logic       do_plain;
    logic [7:0] pcol;
    cmd_t       cmd;

    assign s_tready  = !q_stat.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // classification and state update for one byte
    always_comb
    begin
        phase_next = phase_reg;
        para_next  = para_reg;
        col_next   = col_reg;
        do_plain   = 1'b0;
        pcol       = col_reg;
        cmd.prefix = PFX_NONE;
        cmd.body   = BODY_NONE;
        cmd.chr    = s_tdata;
        if (accept)
        begin
            if (s_tdata == CH_NUL)
            begin
                phase_next = PH_TEXT;
                para_next  = 1'b0;
                col_next   = 8'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_HELD, PH_HELD_WS:
                    begin
                        if (is_ws(s_tdata))
                        begin
                            if (phase_reg == PH_HELD && s_tdata == CH_LF)
                                para_next = 1'b1;
                            phase_next = PH_HELD_WS;
                        end
                        else
                        begin
                            cmd.prefix = para_reg ? PFX_PARA : PFX_BR;
                            para_next  = 1'b0;
                            pcol       = 8'd0;
                            phase_next = PH_TEXT;
                            do_plain   = 1'b1;
                        end
                    end
                    PH_SWALLOW:
                    begin
                        if (!is_ws(s_tdata))
                        begin
                            phase_next = PH_TEXT;
                            do_plain   = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (s_tdata == CH_LF)
                        begin
                            phase_next = PH_HELD;
                            para_next  = 1'b0;
                        end
                        else
                            do_plain = 1'b1;
                    end
                endcase

                // plain text encoding
                if (do_plain)
                begin
                    case (s_tdata)
                        CH_AMP:
                        begin
                            cmd.body = BODY_AMP;
                            col_next = sat_add(pcol, 3'd5);
                        end
                        CH_LT:
                        begin
                            cmd.body = BODY_LT;
                            col_next = sat_add(pcol, 3'd4);
                        end
                        CH_GT:
                        begin
                            cmd.body = BODY_GT;
                            col_next = sat_add(pcol, 3'd4);
                        end
                        CH_SP, CH_TAB:
                        begin
                            if (pcol > wrap_reg)
                            begin
                                cmd.body   = BODY_NL;
                                col_next   = 8'd0;
                                phase_next = PH_SWALLOW;
                            end
                            else
                            begin
                                cmd.body = BODY_LIT;
                                col_next = sat_add(pcol, 3'd1);
                            end
                        end
                        default:
                        begin
                            if (s_tdata >= CH_SP && s_tdata <= CH_TILDE)
                            begin
                                cmd.body = BODY_LIT;
                                col_next = sat_add(pcol, 3'd1);
                            end
                            else
                            begin
                                cmd.body = BODY_REF;
                                col_next = sat_add(pcol, 3'd5);
                            end
                        end
                    endcase
                end

                // end of string
                if (s_tlast)
                begin
                    phase_next = PH_TEXT;
                    para_next  = 1'b0;
                    col_next   = 8'd0;
                end
            end
        end
    end

    assign push     = accept && (cmd.prefix != PFX_NONE || cmd.body != BODY_NONE);
    assign push_cmd = cmd;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg  <= WRAP_RESET;
            phase_reg <= PH_TEXT;
            para_reg  <= 1'b0;
            col_reg   <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                wrap_reg <= cfg_data;
            phase_reg <= phase_next;
            para_reg  <= para_next;
            col_reg   <= col_next;
        end
    end

endmodule

[src/htenc_queue.sv]
// short command queue between the front end and the expander
// depends on htenc_pkg
module htenc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  htenc_pkg::cmd_t     push_cmd,
    input  logic                pop,
    output htenc_pkg::cmd_t     head_cmd,
    output htenc_pkg::q_stat_t  q_stat
);
    import htenc_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign head_cmd     = slot_reg[rptr_reg];
    assign q_stat.full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_cmd;
    end

endmodule

[src/htenc_back.sv]
// expander: walks the head command one output byte per cycle, while the output
// is not stalled, into a registered output stage; depends on htenc_pkg
module htenc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  htenc_pkg::cmd_t     head_cmd,
    input  htenc_pkg::q_stat_t  q_stat,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // out_byte
    output logic                m_tlast    // run_last
);
    import htenc_pkg::*;

    logic [3:0]  pos_reg;
    logic        ovalid_reg;
    logic [7:0]  obyte_reg;
    logic        olast_reg;
    logic        step;
    logic [3:0]  plen, blen, total, bpos, nd, dsel;
    logic [11:0] bcd;
    logic [7:0]  byte_sel;
    logic        at_end;

    assign step = !q_stat.empty && (!ovalid_reg || m_tready);

    // token lengths
    always_comb
    begin
        bcd  = to_bcd(head_cmd.chr);
        plen = (head_cmd.prefix != PFX_NONE) ? 4'd5 : 4'd0;
        nd   = (head_cmd.chr >= 8'd100) ? 4'd3 : ((head_cmd.chr >= 8'd10) ? 4'd2 : 4'd1);
        case (head_cmd.body)
            BODY_AMP: blen = 4'd5;
            BODY_LT:  blen = 4'd4;
            BODY_GT:  blen = 4'd4;
            BODY_REF: blen = 4'd3 + nd;
            BODY_NONE: blen = 4'd0;
            default:  blen = 4'd1;
        endcase
        total  = plen + blen;
        bpos   = pos_reg - plen;
        dsel   = bpos + 4'd1 - nd;
        at_end = (pos_reg == total - 4'd1);
    end

    // byte at the current position
    always_comb
    begin
        byte_sel = head_cmd.chr;
        if (pos_reg < plen)
            byte_sel = str_byte((head_cmd.prefix == PFX_PARA) ? STR_PARA : STR_BR,
                                pos_reg[2:0]);
        else
        begin
            case (head_cmd.body)
                BODY_AMP: byte_sel = str_byte(STR_AMP, bpos[2:0]);
                BODY_LT:  byte_sel = str_byte(STR_LT, bpos[2:0]);
                BODY_GT:  byte_sel = str_byte(STR_GT, bpos[2:0]);
                BODY_NL:  byte_sel = CH_LF;
                BODY_REF:
                begin
                    if (bpos == 4'd0)
                        byte_sel = CH_AMP;
                    else if (bpos == 4'd1)
                        byte_sel = CH_HSH;
                    else if (bpos == 4'd2 + nd)
                        byte_sel = CH_SEMI;
                    else
                    begin
                        case (dsel)
                            4'd0: byte_sel = CH_ZERO + {4'd0, bcd[11:8]};
                            4'd1: byte_sel = CH_ZERO + {4'd0, bcd[7:4]};
                            default: byte_sel = CH_ZERO + {4'd0, bcd[3:0]};
                        endcase
                    end
                end
                default: byte_sel = head_cmd.chr;
            endcase
        end
    end

    assign pop = step && at_end;

    // position counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 4'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (step)
                pos_reg <= at_end ? 4'd0 : pos_reg + 4'd1;
            if (step)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            obyte_reg <= byte_sel;
            olast_reg <= at_end;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tlast  = olast_reg;

endmodule

[src/html_text_encoder_core.sv]
// html text encoder, top level: front end, command queue and expander
// depends on htenc_pkg, htenc_front, htenc_queue, htenc_back
//
// Escapes a text stream into HTML, one input byte per word on s_*, one output
// byte per word on m_*. A byte is taken every cycle while the four-entry
// command queue has room; the expander emits one output byte per cycle while
// m_tready does not stall it, and an input byte expands into 1 to 11 output
// bytes (a line-break prefix of 5 plus a reference of up to 6), so the input
// stalls once the queue fills. m_tlast marks the last output byte caused by
// one input byte; input bytes that cause no output produce no word.
// wrap_column is written on cfg_* (reset 70) and must change only when idle.
module html_text_encoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // run_last
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data   // wrap_column
);
    import htenc_pkg::*;

    logic    push, pop;
    cmd_t    push_cmd, head_cmd;
    q_stat_t q_stat;

    // byte classification
    htenc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // decoupling queue
    htenc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // output expansion
    htenc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // queue never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("command queue overflow");

    // queue never read while empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("command queue underflow");

    // no output word appears without a queued command behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.empty && !m_tvalid) |=> !m_tvalid)
        else $error("output word without command");
`endif

endmodule
